@@ rtl/pbs_pkg.sv @@
package pbs_pkg;

    localparam int unsigned COORD_WIDTH_DEF = 32;
    localparam int unsigned FRAC_BITS_DEF   = 16;

    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_ARC  = 1'b1;

endpackage

@@ rtl/polyline_bulge_segmenter.sv @@
// Polyline bulge segmenter.
// Slave channel takes one vertex per word: tdata = x, y, bulge (signed
// Q16.16 each, lowest first); tuser = first, last, closed (bit 0 up).
// Master channel gives one segment per word: tdata = kind, start x/y,
// end x/y, centre x/y, clockwise, opens_run, saturated, zero padded;
// tlast marks the final segment caused by the vertex.
// A vertex yields zero, one or two segments. The front part stores the
// edges in a two-entry queue and takes the next vertex once it drains.
// A straight segment goes from the idle state directly to the output
// register; an arc runs a one-bit-a-cycle divider over 2*COORD_WIDTH+4
// bits (68 at defaults), then clamp, multiply and sum stages, before
// it reaches the output register.
// The result is held in an output register until tready; a stalled
// receiver halts the back part, and the front takes no vertex while
// the queue still holds edges. Synchronous reset clears the stored
// vertex, first vertex and straight run state to zero, and empties the
// queue.
module polyline_bulge_segmenter
    import pbs_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [3*COORD_WIDTH-1:0]  s_axis_tdata,  // x, y, bulge
    input  logic [2:0]                s_axis_tuser,  // first, last, closed
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // kind, start_x, start_y, end_x, end_y, center_x, center_y, clockwise,
    // opens_run, saturated, zero pad
    output logic [((6*COORD_WIDTH+4+7)/8)*8-1:0] m_axis_tdata,
    output logic                      m_axis_tlast
);

    localparam int unsigned CW = COORD_WIDTH;
    localparam int unsigned OW = ((6*COORD_WIDTH+4+7)/8)*8;

    logic          qv, qr, ql, qo;
    logic [CW-1:0] x1, y1, x2, y2, b;
    logic [6*CW+4:0] seg;

    pbs_front #(.COORD_WIDTH(CW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_x     (s_axis_tdata[CW-1:0]),
        .i_y     (s_axis_tdata[2*CW-1:CW]),
        .i_b     (s_axis_tdata[3*CW-1:2*CW]),
        .i_first (s_axis_tuser[0]),
        .i_last  (s_axis_tuser[1]),
        .i_closed(s_axis_tuser[2]),
        .o_valid (qv),
        .i_ready (qr),
        .o_x1    (x1),
        .o_y1    (y1),
        .o_x2    (x2),
        .o_y2    (y2),
        .o_b     (b),
        .o_open  (qo),
        .o_last  (ql)
    );

    pbs_back #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(qv),
        .o_ready(qr),
        .i_x1   (x1),
        .i_y1   (y1),
        .i_x2   (x2),
        .i_y2   (y2),
        .i_b    (b),
        .i_open (qo),
        .i_last (ql),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_seg  (seg)
    );

    assign m_axis_tdata = OW'(seg[6*CW+3:0]);
    assign m_axis_tlast = seg[6*CW+4];

endmodule

@@ rtl/pbs_front.sv @@
module pbs_front
    import pbs_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_WIDTH-1:0] i_x,
    input  logic [COORD_WIDTH-1:0] i_y,
    input  logic [COORD_WIDTH-1:0] i_b,
    input  logic                   i_first,
    input  logic                   i_last,
    input  logic                   i_closed,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COORD_WIDTH-1:0] o_x1,
    output logic [COORD_WIDTH-1:0] o_y1,
    output logic [COORD_WIDTH-1:0] o_x2,
    output logic [COORD_WIDTH-1:0] o_y2,
    output logic [COORD_WIDTH-1:0] o_b,
    output logic                   o_open,
    output logic                   o_last
);

    // edge queue deep enough for every edge that a vertex can yield (a first edge and a closing edge)
    localparam int unsigned EW = 5 * COORD_WIDTH + 2;

    logic [EW-1:0]          r_q [2];
    logic                   r_wp, r_rp;
    logic [1:0]             r_cnt;
    logic [COORD_WIDTH-1:0] r_px, r_py, r_pb, r_sx, r_sy;
    logic                   r_run;

    logic          acc, pop, closing, e0, e1;
    logic          op0, op1, run0, n_run;
    logic [EW-1:0] w0, w1;
    logic [1:0]    nw;

    assign o_ready = (r_cnt == 2'd0);
    assign acc     = i_valid && o_ready;
    assign closing = i_last && i_closed;
    assign e0      = !i_first;
    assign e1      = closing;

    // straight run tracking: a straight edge opens a run unless one is open
    assign op0   = (r_pb == '0) && !r_run;
    assign run0  = !i_first && (r_pb == '0);
    assign op1   = (i_b == '0) && !run0;
    assign n_run = closing ? (i_b == '0) : run0;

    assign w0 = {r_px, r_py, i_x, i_y, r_pb, op0, !closing};
    assign w1 = {i_x, i_y, (i_first ? i_x : r_sx), (i_first ? i_y : r_sy), i_b, op1, 1'b1};
    assign nw = {1'b0, e0} + {1'b0, e1};

    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign {o_x1, o_y1, o_x2, o_y2, o_b, o_open, o_last} = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
            r_px <= '0; r_py <= '0; r_pb <= '0; r_sx <= '0; r_sy <= '0;
            r_run <= 1'b0;
        end else begin
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (acc) begin
                if (e0 && e1) begin
                    r_q[r_wp] <= w0; r_q[~r_wp] <= w1;
                end else if (e0) begin
                    r_q[r_wp] <= w0;
                end else if (e1) begin
                    r_q[r_wp] <= w1;
                end
                r_wp <= r_wp ^ (nw == 2'd1);
                r_cnt <= nw;
                r_px <= i_x; r_py <= i_y; r_pb <= i_b;
                r_run <= n_run;
                if (i_first) begin
                    r_sx <= i_x; r_sy <= i_y;
                end
            end else if (pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

@@ rtl/pbs_div.sv @@
module pbs_div #(
    parameter int unsigned W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);

    // unsigned restoring divider, one bit a cycle
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_q, r_d;
    logic [W:0]    r_r;
    logic [CW-1:0] r_n;
    logic          r_busy, r_done;
    logic [W:0]    sh, df;

    assign sh     = {r_r[W-1:0], r_q[W-1]};
    assign df     = sh - {1'b0, r_d};
    assign o_done = r_done;
    assign o_quo  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_n <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q <= i_num; r_d <= i_den; r_r <= '0;
                r_n <= CW'(W); r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!df[W]) begin
                    r_r <= df; r_q <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_r <= sh; r_q <= {r_q[W-2:0], 1'b0};
                end
                r_n <= r_n - CW'(1);
                if (r_n == CW'(1)) begin
                    r_busy <= 1'b0; r_done <= 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/pbs_back.sv @@
module pbs_back
    import pbs_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_WIDTH-1:0] i_x1,
    input  logic [COORD_WIDTH-1:0] i_y1,
    input  logic [COORD_WIDTH-1:0] i_x2,
    input  logic [COORD_WIDTH-1:0] i_y2,
    input  logic [COORD_WIDTH-1:0] i_b,
    input  logic                   i_open,
    input  logic                   i_last,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [6*COORD_WIDTH+4:0] o_seg
);

    localparam int unsigned CW = COORD_WIDTH;
    localparam int unsigned DW = 2 * CW + 4;
    localparam int unsigned PW = 2 * CW + 2;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_CLAMP, S_MUL, S_SUM, S_OUT} t_state;

    t_state r_st;
    logic signed [CW-1:0] r_x1, r_y1, r_x2, r_y2, r_b, r_k, r_cx, r_cy;
    logic                 r_last, r_sat, r_open, r_arc;
    logic                 r_neg;
    logic signed [PW-1:0] r_ox, r_oy;
    logic                 r_start;
    logic [DW-1:0]        r_dnum, r_dden;
    logic                 div_done;
    logic [DW-1:0]        div_q;

    logic signed [DW-1:0] bs, bb, ff, nm, qs;
    logic signed [CW:0]   dx, dy;
    logic signed [CW+1:0] mx, my;
    logic signed [PW+1:0] sx, sy;
    logic signed [CW-1:0] smax, smin;

    assign smax = {1'b0, {(CW-1){1'b1}}};
    assign smin = {1'b1, {(CW-1){1'b0}}};
    assign bs = DW'($signed(i_b));
    assign bb = bs * bs;
    assign ff = DW'(1) <<< (2 * FRAC_BITS);
    assign nm = ff - bb;
    assign qs = r_neg ? -$signed(div_q) : $signed(div_q);
    assign dx = {r_x2[CW-1], r_x2} - {r_x1[CW-1], r_x1};
    assign dy = {r_y2[CW-1], r_y2} - {r_y1[CW-1], r_y1};
    assign mx = $signed({{2{r_x1[CW-1]}}, r_x1} + {{2{r_x2[CW-1]}}, r_x2}) >>> 1;
    assign my = $signed({{2{r_y1[CW-1]}}, r_y1} + {{2{r_y2[CW-1]}}, r_y2}) >>> 1;
    assign sx = (PW+2)'(mx) + (PW+2)'(r_ox >>> FRAC_BITS);
    assign sy = (PW+2)'(my) + (PW+2)'(r_oy >>> FRAC_BITS);

    pbs_div #(.W(DW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_start),
        .i_num  (r_dnum),
        .i_den  (r_dden),
        .o_done (div_done),
        .o_quo  (div_q)
    );

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_seg = {r_last, r_sat, r_open, r_arc && r_b[CW-1], r_cy, r_cx,
                    r_y2, r_x2, r_y1, r_x1, r_arc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_open <= 1'b0; r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x1 <= i_x1; r_y1 <= i_y1; r_x2 <= i_x2; r_y2 <= i_y2;
                        r_b <= i_b; r_last <= i_last; r_sat <= 1'b0;
                        r_cx <= '0; r_cy <= '0;
                        r_open <= i_open;
                        if (i_b == '0) begin
                            r_arc <= 1'b0;
                            r_st <= S_OUT;
                        end else begin
                            r_arc <= 1'b1; r_st <= S_DIV; r_start <= 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_st <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    if (qs > DW'(smax)) begin
                        r_k <= smax; r_sat <= 1'b1;
                    end else if (qs < DW'(smin)) begin
                        r_k <= smin; r_sat <= 1'b1;
                    end else begin
                        r_k <= CW'(qs);
                    end
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    r_ox <= PW'(-(PW'(dy)) * PW'(r_k));
                    r_oy <= PW'(PW'(dx) * PW'(r_k));
                    r_st <= S_SUM;
                end
                S_SUM: begin
                    if (sx > (PW+2)'(smax)) begin
                        r_cx <= smax; r_sat <= 1'b1;
                    end else if (sx < (PW+2)'(smin)) begin
                        r_cx <= smin; r_sat <= 1'b1;
                    end else begin
                        r_cx <= CW'(sx);
                    end
                    if (sy > (PW+2)'(smax)) begin
                        r_cy <= smax; r_sat <= 1'b1;
                    end else if (sy < (PW+2)'(smin)) begin
                        r_cy <= smin; r_sat <= 1'b1;
                    end else begin
                        r_cy <= CW'(sy);
                    end
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // divider operands: magnitudes, sign kept aside
    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_valid) begin
            r_dnum <= nm[DW-1] ? DW'(-nm) : nm;
            r_dden <= i_b[CW-1] ? DW'(-(bs <<< 2)) : DW'(bs <<< 2);
            r_neg  <= nm[DW-1] ^ i_b[CW-1];
        end
    end

endmodule

@@ tb/polyline_bulge_segmenter_tb.sv @@
module polyline_bulge_segmenter_tb;
    import pbs_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int OW = ((6*CW+4+7)/8)*8;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] bulge;
        logic        first;
        logic        last;
        logic        closed;
    } vertex_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] cx;
        logic [31:0] cy;
        logic        cw;
        logic        opens;
        logic        sat;
        logic        last;
    } segment_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [3*CW-1:0] s_axis_tdata = '0;
    logic [2:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OW-1:0] m_axis_tdata;
    logic m_axis_tlast;

    polyline_bulge_segmenter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    vertex_t  pending_vertices[$];
    segment_t expected_segments[$];
    int  mismatches = 0;
    int  send_idle_pct = 27;
    int  recv_idle_pct = 63;
    int  hold_off = 0;
    bit  stimulus_done = 1'b0;
    bit  in_taken = 1'b0;
    longint cycle_count = 0;

    longint pv_x = 0, pv_y = 0, pv_b = 0, first_x = 0, first_y = 0;
    bit run_is_open = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic add_vertex(vertex_t v);
        pending_vertices.insert(pending_vertices.size(), v);
    endtask

    task automatic add_expected(segment_t s);
        expected_segments.insert(expected_segments.size(), s);
    endtask

    function automatic longint clamp_coord(longint v, ref bit sat);
        longint hi;
        longint lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic segment_t make_segment(longint x1, longint y1, longint x2,
                                              longint y2, longint b, bit last);
        segment_t s;
        longint f, k, dx, dy, cx, cy;
        bit sat;
        sat = 1'b0;
        cx = 0;
        cy = 0;
        if (b != 0) begin
            f = 64'sd1 <<< FB;
            dx = x2 - x1;
            dy = y2 - y1;
            k = (f * f - b * b) / (4 * b);
            k = clamp_coord(k, sat);
            cx = clamp_coord(((x1 + x2) >>> 1) + ((-dy * k) >>> FB), sat);
            cy = clamp_coord(((y1 + y2) >>> 1) + ((dx * k) >>> FB), sat);
            run_is_open = 1'b0;
            s.opens = 1'b0;
        end else begin
            s.opens = !run_is_open;
            run_is_open = 1'b1;
        end
        s.kind = (b != 0) ? KIND_ARC : KIND_LINE;
        s.sx = x1[31:0];
        s.sy = y1[31:0];
        s.ex = x2[31:0];
        s.ey = y2[31:0];
        s.cx = cx[31:0];
        s.cy = cy[31:0];
        s.cw = (b < 0);
        s.sat = sat;
        s.last = last;
        return s;
    endfunction

    task automatic segment_vertex(vertex_t v);
        longint x, y, b;
        bit closing;
        x = longint'($signed(v.x));
        y = longint'($signed(v.y));
        b = longint'($signed(v.bulge));
        closing = v.last && v.closed;
        if (v.first) begin
            first_x = x;
            first_y = y;
            run_is_open = 1'b0;
        end else begin
            add_expected(make_segment(pv_x, pv_y, x, y, pv_b, !closing));
        end
        pv_x = x;
        pv_y = y;
        pv_b = b;
        if (closing)
            add_expected(make_segment(x, y, first_x, first_y, b, 1'b1));
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7fffffff - $urandom_range(0, 3);
            2: return 32'h80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
        endcase
    endfunction

    function automatic logic [31:0] rand_bulge();
        case ($urandom_range(0, 7))
            0, 1, 2: return '0;
            3: return $urandom;
            4: return $urandom_range(1, 3);
            5: return -$urandom_range(1, 3);
            default: return $signed($urandom_range(0, 32'h00040000)) - 32'sh00020000;
        endcase
    endfunction

    function automatic vertex_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] b,
                                   bit f, bit l, bit c);
        vertex_t v;
        v.x = x;
        v.y = y;
        v.bulge = b;
        v.first = f;
        v.last = l;
        v.closed = c;
        return v;
    endfunction

    initial begin
        int n, len;
        add_vertex(mk(32'h00010000, 32'h00020000, 0, 0, 0, 0));
        add_vertex(mk(32'h00050000, 32'h00050000, 0, 1, 1, 0));
        add_vertex(mk(32'h00050000, 32'h00050000, 32'h00010000, 1, 1, 1));
        add_vertex(mk(32'h00030000, 32'h00030000, 0, 1, 1, 1));
        add_vertex(mk(0, 0, 32'h00010000, 1, 0, 0));
        add_vertex(mk(32'h00020000, 0, 32'hffff0000, 0, 0, 1));
        add_vertex(mk(32'h00020000, 0, 32'h00008000, 0, 0, 0));
        add_vertex(mk(32'h7fffffff, 32'h80000000, 32'h00000001, 0, 0, 0));
        add_vertex(mk(32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0));
        add_vertex(mk(32'hffffffff, 32'hffffffff, 32'h7fffffff, 0, 0, 0));
        add_vertex(mk(32'h7fffffff, 32'h7fffffff, 32'hffffffff, 0, 1, 1));
        add_vertex(mk(0, 0, 0, 1, 0, 0));
        add_vertex(mk(32'h00010000, 0, 0, 0, 0, 0));
        add_vertex(mk(32'h00010000, 32'h00010000, 32'h00004000, 0, 0, 0));
        add_vertex(mk(0, 32'h00010000, 0, 0, 1, 1));
        add_vertex(mk(32'h80000000, 32'h80000000, 0, 0, 1, 0));
        n = pending_vertices.size();
        while (n < 1250) begin
            if ($urandom_range(0, 9) == 0) begin
                add_vertex(mk(rand_coord(), rand_coord(), rand_bulge(),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1))));
                n++;
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    add_vertex(mk(rand_coord(), rand_coord(), rand_bulge(),
                        i == 0, i == len - 1, 1'($urandom_range(0, 1))));
                end
                n += len;
            end
        end
        stimulus_done = 1'b1;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || in_taken) begin
                if (pending_vertices.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {pending_vertices[0].bulge, pending_vertices[0].y,
                                     pending_vertices[0].x};
                    s_axis_tuser <= {pending_vertices[0].closed, pending_vertices[0].last,
                                     pending_vertices[0].first};
                    segment_vertex(pending_vertices.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (hold_off > 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // input word taken at this edge
    always @(posedge i_clk) begin
        in_taken <= s_axis_tvalid && s_axis_tready;
    end

    // long receiver stall so the input backs up
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == 20000)
            hold_off <= 3000;
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    always @(posedge i_clk) begin
        segment_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_segments.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected word tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                want = expected_segments.pop_front();
                if (m_axis_tlast !== want.last
                    || m_axis_tdata[OW-1:6*CW+4] !== '0
                    || m_axis_tdata[6*CW+3:0] !== {want.sat, want.opens, want.cw,
                       want.cy, want.cx, want.ey, want.ex, want.sy, want.sx, want.kind}) begin
                    if (mismatches < 10)
                        $display("mismatch: expected %p got tdata %h tlast %b",
                                 want, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_vertices.size() < 800);
        send_idle_pct = 63;
        recv_idle_pct = 27;
        wait (pending_vertices.size() < 400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait (stimulus_done && pending_vertices.size() == 0);
        @(posedge i_clk);
        while (s_axis_tvalid) @(posedge i_clk);
        while (expected_segments.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_segments.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        wait (cycle_count >= LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule
